### hdl/tcbm_pkg.sv
`default_nettype none
package tcbm_pkg;

  localparam int RowW = 64;
  localparam int IdW  = 6;
  localparam int CntW = 7;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_QUERY  = 3'd2,
    OP_START  = 3'd3,
    OP_FILTER = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  localparam logic [1:0] FK_BEFORE = 2'd0;
  localparam logic [1:0] FK_AFTER  = 2'd1;
  localparam logic [1:0] FK_UNORD  = 2'd2;

  typedef struct packed {
    logic [2:0]     operation;
    logic [IdW-1:0] first_op;
    logic [IdW-1:0] second_op;
    logic [1:0]     filter_kind;
    logic           combine_mode;
  } req_t;

  typedef struct packed {
    logic            status;
    logic            ordered;
    logic [RowW-1:0] row_bits;
    logic [CntW-1:0] row_count;
  } rsp_t;

endpackage
`default_nettype wire

### hdl/tcbm_mem.sv
`default_nettype none
module tcbm_mem import tcbm_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clr_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [RowW-1:0]          wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [RowW-1:0]          rdata_o
);

  logic [RowW-1:0]  mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [RowW-1:0]  rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // rows never written since the last clear read as zero
    rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hdl/transitive_closure_bit_matrix_unit.sv
`default_nettype none
// Reachability store for a directed acyclic graph of up to MAX_OPS nodes.
// Command channel: a transaction is taken at a clock edge with start high and
// busy low; req_i carries operation, node ids, filter kind and combine mode.
// Every command returns one result: done_o is high for exactly one cycle and
// rsp_o holds status, ordered flag, accumulator row and its popcount. The
// receiver cannot stall; the result is only valid in the done_o cycle.
// Config: cfg_data_i sets the node count, written when cfg_valid_i is high
// (cfg_ready_o is always high); only change it while the block is idle.
// Steps from accept to done_o: clear, start, read and a rejected id go through
// S_POP and S_OUT; query and filter first read rows (S_RD) and evaluate (S_EX);
// edge insert reads rows (S_IRS, S_IRD), checks (S_ICHK) and walks the rows of
// both matrices in parallel, one read and one write port each, one row per cycle.
// busy stays high until the cycle of done_o, so one command is in flight.
// Reset empties both matrices (row valid flags), clears the accumulator,
// selects intersection mode and sets the node count to MAX_OPS.
module transitive_closure_bit_matrix_unit import tcbm_pkg::*; #(
  parameter int MAX_OPS = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire req_t            req_i,
  output logic                 done_o,
  output rsp_t                 rsp_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [CntW-1:0] cfg_data_i
);

  localparam int IW = $clog2(MAX_OPS);
  localparam logic [CntW-1:0] MaxN = CntW'(MAX_OPS);

  typedef enum logic [3:0] {
    S_IDLE, S_IRS, S_IRD, S_ICHK, S_ILD, S_ILP, S_RD, S_EX, S_POP, S_OUT
  } state_e;

  state_e          state_q;
  req_t            req_q;
  logic [CntW-1:0] n_q;
  logic [RowW-1:0] acc_q;
  logic            mode_q;
  logic            status_q;
  logic            ordered_q;
  logic [IW-1:0]   idx_q;
  logic [RowW-1:0] srow_q [2];
  logic            en_q [2];
  logic [4:0]      pc_q [4];
  logic            done_q;
  rsp_t            rsp_q;

  logic [IdW-1:0]  src [2];
  logic [IdW-1:0]  dst [2];
  logic [RowW-1:0] rdata [2];
  logic [RowW-1:0] nv [2];
  logic            we [2];
  logic [IW-1:0]   waddr [2];
  logic [IW-1:0]   raddr [2];
  logic            clr;
  logic [RowW-1:0] mask;
  logic [CntW-1:0] nm1;
  logic [CntW-1:0] cfg_n;
  logic            err_pair;
  logic            err_filt;
  logic [RowW-1:0] frow;

  assign src[0] = req_q.first_op;
  assign dst[0] = req_q.second_op;
  assign src[1] = req_q.second_op;
  assign dst[1] = req_q.first_op;

  assign mask = (n_q >= CntW'(RowW)) ? '1 : ((RowW'(1) << n_q) - RowW'(1));
  assign nm1  = n_q - CntW'(1);

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_n = CntW'(1);
    end else if (cfg_data_i > MaxN) begin
      cfg_n = MaxN;
    end else begin
      cfg_n = cfg_data_i;
    end
  end

  assign err_pair = (CntW'(req_i.first_op) >= n_q) || (CntW'(req_i.second_op) >= n_q);
  assign err_filt = (CntW'(req_i.first_op) >= n_q) || (req_i.filter_kind > FK_UNORD);
  assign clr = (state_q == S_IDLE) && start && (req_i.operation == OP_CLEAR);

  // per-matrix read-modify-write control, index 0 before, index 1 after
  always_comb begin
    for (int x = 0; x < 2; x++) begin
      nv[x]    = rdata[x] | (RowW'(1) << src[x]) | srow_q[x];
      we[x]    = 1'b0;
      waddr[x] = idx_q;
      raddr[x] = '0;
      case (state_q)
        S_IRS: raddr[x] = src[x][IW-1:0];
        S_IRD: raddr[x] = dst[x][IW-1:0];
        S_ICHK: begin
          we[x]    = !rdata[x][src[x]];
          waddr[x] = dst[x][IW-1:0];
        end
        S_ILD: raddr[x] = idx_q;
        S_ILP: begin
          we[x]    = en_q[x] && rdata[x][dst[x]] && !rdata[x][src[x]];
          raddr[x] = idx_q + IW'(1);
        end
        S_RD: begin
          if (x == 0 && req_q.operation == OP_QUERY) begin
            raddr[x] = req_q.second_op[IW-1:0];
          end else begin
            raddr[x] = req_q.first_op[IW-1:0];
          end
        end
        default: raddr[x] = '0;
      endcase
    end
  end

  always_comb begin
    case (req_q.filter_kind)
      FK_BEFORE: frow = rdata[0];
      FK_AFTER:  frow = rdata[1];
      default:   frow = ~(rdata[0] | rdata[1]) & ~(RowW'(1) << req_q.first_op);
    endcase
    frow = frow & mask;
  end

  for (genvar g = 0; g < 2; g++) begin : g_mat
    tcbm_mem #(.DEPTH(MAX_OPS)) u_mem (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (clr),
      .we_i    (we[g]),
      .waddr_i (waddr[g]),
      .wdata_i (nv[g]),
      .raddr_i (raddr[g]),
      .rdata_o (rdata[g])
    );
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (start) req_q <= req_i;
      S_IRD: begin
        srow_q[0] <= rdata[0];
        srow_q[1] <= rdata[1];
      end
      S_ICHK: begin
        for (int x = 0; x < 2; x++) begin
          if (we[x] && dst[x] == src[x]) srow_q[x] <= nv[x];
        end
      end
      S_ILP: begin
        for (int x = 0; x < 2; x++) begin
          if (we[x] && IdW'(idx_q) == src[x]) srow_q[x] <= nv[x];
        end
      end
      S_POP: begin
        for (int i = 0; i < 4; i++) begin
          pc_q[i] <= 5'($countones(acc_q[16*i +: 16]));
        end
      end
      S_OUT: begin
        rsp_q.status    <= status_q;
        rsp_q.ordered   <= ordered_q;
        rsp_q.row_bits  <= acc_q;
        rsp_q.row_count <= CntW'(pc_q[0]) + CntW'(pc_q[1]) + CntW'(pc_q[2])
                         + CntW'(pc_q[3]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      n_q       <= MaxN;
      acc_q     <= '0;
      mode_q    <= 1'b0;
      status_q  <= 1'b0;
      ordered_q <= 1'b0;
      idx_q     <= '0;
      en_q[0]   <= 1'b0;
      en_q[1]   <= 1'b0;
    end else begin
      done_q <= (state_q == S_OUT);
      if (cfg_valid_i) n_q <= cfg_n;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            ordered_q <= 1'b0;
            case (req_i.operation)
              OP_INSERT: begin
                status_q <= err_pair;
                state_q  <= err_pair ? S_POP : S_IRS;
              end
              OP_QUERY: begin
                status_q <= err_pair;
                state_q  <= err_pair ? S_POP : S_RD;
              end
              OP_START: begin
                status_q <= 1'b0;
                mode_q   <= req_i.combine_mode;
                acc_q    <= req_i.combine_mode ? '0 : mask;
                state_q  <= S_POP;
              end
              OP_FILTER: begin
                status_q <= err_filt;
                state_q  <= err_filt ? S_POP : S_RD;
              end
              default: begin
                status_q <= 1'b0;
                state_q  <= S_POP;
              end
            endcase
          end
        end
        S_IRS: state_q <= S_IRD;
        S_IRD: state_q <= S_ICHK;
        S_ICHK: begin
          en_q[0] <= we[0];
          en_q[1] <= we[1];
          idx_q   <= '0;
          state_q <= S_ILD;
        end
        S_ILD: state_q <= S_ILP;
        S_ILP: begin
          if (CntW'(idx_q) == nm1) state_q <= S_POP;
          else idx_q <= idx_q + IW'(1);
        end
        S_RD: state_q <= S_EX;
        S_EX: begin
          if (req_q.operation == OP_QUERY) begin
            ordered_q <= rdata[0][req_q.first_op];
          end else begin
            acc_q <= mode_q ? (acc_q | frow) : (acc_q & frow);
          end
          state_q <= S_POP;
        end
        S_POP: state_q <= S_OUT;
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire

### hdl/tcbm_check.sv
`default_nettype none
module tcbm_check import tcbm_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire rsp_t rsp_o
);

  // an accepted transaction raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("command finished without a result");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.row_count == CntW'($countones(rsp_o.row_bits)))
    else $error("popcount does not match row");

  a_err_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status |-> !rsp_o.ordered) else $error("ordered set on error");

endmodule

bind transitive_closure_bit_matrix_unit tcbm_check u_tcbm_check (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
`default_nettype wire
